@@ rtl/core/nod_pkg.sv @@
// ----------------------------------------------------------------------------
// nod_pkg
// Shared types and constants of the 3x3 neighbor outlier denoise block.
// ----------------------------------------------------------------------------
package nod_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int SAMPLE_BITS = 24;

    localparam int VAL_W      = SAMPLE_BITS - 1;
    localparam int DIM_W      = 7;
    localparam int THR_W      = 16;
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS + 2);
    localparam int DIAG_W     = ROW_W + 2;
    localparam int PSUM_W     = VAL_W + 2;
    localparam int PROD_W     = THR_W + VAL_W;
    localparam int MEAN_SH    = 3;
    localparam int THR_FRAC   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [DIM_W-1:0] COLUMNS_RST   = DIM_W'(MAX_COLUMNS);
    localparam logic [DIM_W-1:0] ROWS_RST      = DIM_W'(MAX_ROWS);
    localparam logic [VAL_W-1:0] MAX_TOL_RST   = {VAL_W{1'b1}};
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(4096);

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic             is_last;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] top;
        logic [VAL_W-1:0] mid;
        logic [VAL_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic advance;
        logic zero;
    } t_cell_ctl;

    typedef struct packed {
        logic [VAL_W-1:0] upper;
        logic [VAL_W-1:0] lower;
    } t_lb_word;

    typedef struct packed {
        t_col             left;
        t_col             right;
        logic [VAL_W-1:0] above;
        logic [VAL_W-1:0] center;
        logic [VAL_W-1:0] below;
        logic             diag;
        logic             last;
    } t_judge_in;

endpackage

@@ rtl/core/nod_col_cell.sv @@
// ----------------------------------------------------------------------------
// nod_col_cell
// One window column cell: loads the column of its upstream neighbor.
// ----------------------------------------------------------------------------
module nod_col_cell
    import nod_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_col      i_col,
    output t_col      o_col
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.advance) begin
            r_col <= i_ctl.zero ? '0 : i_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ rtl/core/nod_line_buf.sv @@
// ----------------------------------------------------------------------------
// nod_line_buf
// Two-row line store, one word per column, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module nod_line_buf
    import nod_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  t_lb_word         i_wr_data,
    output t_lb_word         o_rd_data
);

    t_lb_word r_mem [MAX_COLUMNS];
    t_lb_word r_rd;
    t_lb_word r_fwd;
    logic     r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd  <= r_mem[i_rd_addr];
            r_fwd <= i_wr_data;
            r_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_hit ? r_fwd : r_rd;

endmodule

@@ rtl/core/nod_judge.sv @@
// ----------------------------------------------------------------------------
// nod_judge
// Outlier decision pipeline: neighbor mean, deviation and threshold compare.
// ----------------------------------------------------------------------------
module nod_judge
    import nod_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_judge_in        i_data,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data
);

    logic en_o;
    logic en_2;
    logic en_1;

    logic              r1_v;
    logic [PSUM_W-1:0] r1_p0;
    logic [PSUM_W-1:0] r1_p1;
    logic [VAL_W-1:0]  r1_s;
    logic              r1_keep;
    logic              r1_last;
    logic [PROD_W-1:0] r1_prod;

    logic                r2_v;
    logic [VAL_W-1:0]    r2_mean;
    logic [VAL_W-1:0]    r2_diff;
    logic [VAL_W-1:0]    r2_s;
    logic                r2_keep;
    logic                r2_last;
    logic [PROD_W-1:0]   r2_prod;

    logic              r_ov;
    t_out_item         r_out;

    logic [PSUM_W-1:0] n_p0;
    logic [PSUM_W-1:0] n_p1;
    logic [PSUM_W:0]   total;
    logic [VAL_W-1:0]  mean;
    logic [VAL_W-1:0]  diff;
    logic              big;

    assign en_o    = !r_ov || !i_stall;
    assign en_2    = !r2_v || en_o;
    assign en_1    = !r1_v || en_2;
    assign o_ready = en_1;

    assign n_p0 = PSUM_W'(i_data.left.top) + PSUM_W'(i_data.left.mid)
                + PSUM_W'(i_data.left.bot) + PSUM_W'(i_data.above);
    assign n_p1 = PSUM_W'(i_data.right.top) + PSUM_W'(i_data.right.mid)
                + PSUM_W'(i_data.right.bot) + PSUM_W'(i_data.below);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en_1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_1) begin
            r1_p0   <= n_p0;
            r1_p1   <= n_p1;
            r1_s    <= i_data.center;
            r1_keep <= i_data.diag || (i_data.center == '0);
            r1_last <= i_data.last;
            r1_prod <= PROD_W'(i_thr) * PROD_W'(i_data.center);
        end
    end

    assign total = (PSUM_W + 1)'(r1_p0) + (PSUM_W + 1)'(r1_p1);
    assign mean  = total[MEAN_SH +: VAL_W];
    assign diff  = (r1_s > mean) ? (r1_s - mean) : (mean - r1_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en_2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_2) begin
            r2_mean <= mean;
            r2_diff <= diff;
            r2_s    <= r1_s;
            r2_keep <= r1_keep;
            r2_last <= r1_last;
            r2_prod <= r1_prod;
        end
    end

    assign big = PROD_W'({r2_diff, {THR_FRAC{1'b0}}}) > r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out.cell_value <= (!r2_keep && big) ? r2_mean : r2_s;
            r_out.is_last    <= r2_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

@@ rtl/core/neighbour_outlier_denoise_3x3.sv @@
// ----------------------------------------------------------------------------
// neighbour_outlier_denoise_3x3
// Streaming 3x3 outlier replacement filter over a raster-ordered grid.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while o_stall is low, and registers each result
// through the first stage, the two judge stages and the output register; cell i
// of the grid is released by input transaction i + columns + 1, so send
// columns + 1 flush transactions after the last sample to drain the grid. The
// rate is set by the one-read one-write line store, read and written once per
// transaction at the current column, and by the two column cells of the window
// that shift once per transaction. The line store needs no clearing pass after
// reset; configuration writes are taken at any time the block is idle, and a
// columns or rows write restarts the grid.
module neighbour_outlier_denoise_3x3
    import nod_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic             x0;
        logic             top_ok;
        logic             mid_ok;
        logic [VAL_W-1:0] s;
        logic             emit;
        logic             rt_zero;
        logic             diag;
        logic             last;
    } t_s1;

    logic [DIM_W-1:0] r_cols;
    logic [DIM_W-1:0] r_rows;
    logic [VAL_W-1:0] r_max;
    logic [THR_W-1:0] r_thr;

    logic [COL_W-1:0] r_xpos;
    logic [ROW_W-1:0] r_ypos;
    logic [COL_W-1:0] n_xpos;
    logic [ROW_W-1:0] n_ypos;

    logic             r_s1v;
    t_s1              r_s1;
    t_s1              n_s1;

    logic             cfg_wr;
    logic             geo_wr;
    logic [DIM_W-1:0] c_eff;
    logic [DIM_W-1:0] r_eff;
    logic [ROW_W-1:0] r_eff_y;
    logic [COL_W:0]   col_inc;
    logic             ignore;
    logic             accept;
    logic             s1_load;
    logic             s1_adv;
    logic             diag;
    logic             emit_a;
    logic             emit_b;
    logic             last;
    logic [VAL_W-1:0] clip;

    t_lb_word         lb_rd;
    t_lb_word         lb_wr;
    t_col             newcol;
    t_col             col_a;
    t_col             col_b;
    t_col             rt_col;
    t_cell_ctl        ctl_a;
    t_cell_ctl        ctl_b;
    t_judge_in        jin;
    logic             j_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign geo_wr      = cfg_wr && (i_cfg_index inside {CFG_COLUMNS, CFG_ROWS});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLUMNS_RST;
            r_rows <= ROWS_RST;
            r_max  <= MAX_TOL_RST;
            r_thr  <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_COLUMNS:   r_cols <= i_cfg_data[DIM_W-1:0];
                CFG_ROWS:      r_rows <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_TOL:   r_max  <= i_cfg_data[VAL_W-1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                default:       r_thr  <= r_thr;
            endcase
        end
    end

    assign c_eff = (r_cols == '0) ? DIM_W'(1) :
                   (r_cols > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : r_cols;
    assign r_eff = (r_rows == '0) ? DIM_W'(1) :
                   (r_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_rows;
    assign r_eff_y = ROW_W'(r_eff);

    assign ignore = i_data.kind && (r_xpos == '0) && (r_ypos == '0);
    assign diag   = (DIAG_W'(r_xpos) + DIAG_W'(r_eff)) == (DIAG_W'(r_ypos) + DIAG_W'(c_eff));
    assign emit_a = (r_xpos == '0) && (r_ypos >= ROW_W'(2));
    assign emit_b = (r_xpos != '0) && (r_ypos >= ROW_W'(1)) && (r_ypos <= r_eff_y);
    assign last   = (r_xpos == '0) && (r_ypos == r_eff_y + ROW_W'(1));

    always_comb begin
        if (i_data.kind || (r_ypos >= r_eff_y) || i_data.sample_value[SAMPLE_BITS-1]) begin
            clip = '0;
        end else if ((i_data.sample_value[VAL_W-1:0] > r_max) && !diag) begin
            clip = r_max;
        end else begin
            clip = i_data.sample_value[VAL_W-1:0];
        end
    end

    assign col_inc = (COL_W + 1)'(r_xpos) + (COL_W + 1)'(1);

    always_comb begin
        if (last) begin
            n_xpos = '0;
            n_ypos = '0;
        end else if (col_inc >= (COL_W + 1)'(c_eff)) begin
            n_xpos = '0;
            n_ypos = r_ypos + ROW_W'(1);
        end else begin
            n_xpos = col_inc[COL_W-1:0];
            n_ypos = r_ypos;
        end
    end

    always_comb begin
        n_s1.x       = r_xpos;
        n_s1.x0      = (r_xpos == '0);
        n_s1.top_ok  = (r_ypos >= ROW_W'(2));
        n_s1.mid_ok  = (r_ypos >= ROW_W'(1));
        n_s1.s       = clip;
        n_s1.emit    = emit_a || emit_b;
        n_s1.rt_zero = emit_a;
        n_s1.diag    = emit_a ? last : diag;
        n_s1.last    = last;
    end

    assign s1_adv  = r_s1v && (!r_s1.emit || j_ready);
    assign s1_load = !r_s1v || s1_adv;
    assign o_stall = !s1_load;
    assign accept  = i_valid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xpos <= '0;
            r_ypos <= '0;
        end else if (geo_wr) begin
            r_xpos <= '0;
            r_ypos <= '0;
        end else if (accept && !ignore) begin
            r_xpos <= n_xpos;
            r_ypos <= n_ypos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (s1_load) begin
            r_s1v <= accept && !ignore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1 <= n_s1;
        end
    end

    assign lb_wr.upper = lb_rd.lower;
    assign lb_wr.lower = r_s1.s;

    nod_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_xpos),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1.x),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    assign newcol.top = r_s1.top_ok ? lb_rd.upper : '0;
    assign newcol.mid = r_s1.mid_ok ? lb_rd.lower : '0;
    assign newcol.bot = r_s1.s;

    assign ctl_a.advance = s1_adv || geo_wr;
    assign ctl_a.zero    = geo_wr || r_s1.last;
    assign ctl_b.advance = s1_adv || geo_wr;
    assign ctl_b.zero    = geo_wr || r_s1.last || r_s1.x0;

    nod_col_cell u_cell_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_col   (newcol),
        .o_col   (col_a)
    );

    nod_col_cell u_cell_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .i_col   (col_a),
        .o_col   (col_b)
    );

    assign rt_col = r_s1.rt_zero ? '0 : newcol;

    assign jin.left   = col_b;
    assign jin.right  = rt_col;
    assign jin.above  = col_a.top;
    assign jin.center = col_a.mid;
    assign jin.below  = col_a.bot;
    assign jin.diag   = r_s1.diag;
    assign jin.last   = r_s1.last;

    nod_judge u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_adv && r_s1.emit),
        .o_ready (j_ready),
        .i_data  (jin),
        .i_thr   (r_thr),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1v |-> !o_stall)
        else $error("input stalled with an empty first stage");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (COL_W + 1)'(r_xpos) < (COL_W + 1)'(c_eff))
        else $error("column position beyond grid width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ypos <= r_eff_y + ROW_W'(1))
        else $error("row position beyond drain row");
`endif

endmodule
